FILE: rtl/core/psb_pkg.sv
// ----------------------------------------------------------------------------
// Priority slot buffer package
// Sizes, field widths, status codes and the structs shared by the buffer's
// sequencer and its scan unit.
// ----------------------------------------------------------------------------
`default_nettype none

package psb_pkg;

    localparam int SLOTS   = 16;
    localparam int SOURCES = 4;

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int SIDX_W = (SOURCES > 1) ? $clog2(SOURCES) : 1;

    localparam int VAL_W  = 32;
    localparam int PRIO_W = 8;
    localparam int SRC_W  = 2;
    localparam int LIFE_W = 4;
    localparam int TIME_W = 32;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic [PRIO_W-1:0] prio;
        logic [SRC_W-1:0]  source;
        logic [TIME_W-1:0] created;
        logic [LIFE_W-1:0] lifetime;
    } slot_rec_t;

    typedef struct packed {
        logic              start;
        logic              sample;
        logic              is_remove;
        logic              cand;
        logic [IDX_W-1:0]  idx;
        logic [PRIO_W-1:0] key;
    } scan_ctl_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] best_idx;
    } scan_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/priority_slot_buffer_with_expiry.sv
// ----------------------------------------------------------------------------
// Priority slot buffer with expiry
// Slot store with lowest-free-slot insert and smallest-priority remove,
// expiry check against the insertion time and running value sums.
// ----------------------------------------------------------------------------
// A refused insert or remove skips the scan. The scan reads one slot per
// cycle from the single read port of the slot memory. One word is worked
// on at a time; the next word can be taken in the cycle after the result
// is loaded into the output.
// Reset clears valid bits, occupancy and sums at once; slot contents are not.
`default_nettype none

module priority_slot_buffer_with_expiry (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  wire                                 action,
    input  wire  signed [psb_pkg::VAL_W-1:0]    item_value,
    input  wire         [psb_pkg::PRIO_W-1:0]   item_priority,
    input  wire         [psb_pkg::SRC_W-1:0]    item_source,
    input  wire         [psb_pkg::LIFE_W-1:0]   item_lifetime,
    input  wire         [psb_pkg::TIME_W-1:0]   now_seconds,
    output logic                                out_valid,
    input  wire                                 out_stall,
    output logic        [psb_pkg::STAT_W-1:0]   status,
    output logic signed [psb_pkg::VAL_W-1:0]    out_value,
    output logic        [psb_pkg::PRIO_W-1:0]   out_priority,
    output logic        [psb_pkg::SRC_W-1:0]    out_source,
    output logic                                expired,
    output logic signed [psb_pkg::VAL_W-1:0]    total_sum,
    output logic signed [psb_pkg::VAL_W-1:0]    source_sum,
    output logic        [psb_pkg::OCC_W-1:0]    occupancy
);
    import psb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_FETCH,
        S_LOAD,
        S_CHECK,
        S_ACCUM,
        S_DONE
    } state_t;

    typedef struct packed {
        status_t           status;
        logic [VAL_W-1:0]  value;
        logic [PRIO_W-1:0] prio;
        logic [SRC_W-1:0]  source;
        logic              expired;
        logic [VAL_W-1:0]  ssum;
    } result_t;

    state_t            state_reg;
    logic [IDX_W:0]    scan_cnt_reg;
    logic              smp_vld_reg;
    logic [IDX_W-1:0]  smp_idx_reg;
    logic [SLOTS-1:0]  active_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [VAL_W-1:0]  total_reg;
    logic [VAL_W-1:0]  src_sum_reg [SOURCES];
    result_t           res_reg;
    logic              out_valid_reg;
    result_t           out_res_reg;
    logic [VAL_W-1:0]  out_total_reg;
    logic [OCC_W-1:0]  out_occ_reg;

    // Item registers, loaded on acceptance.
    logic              act_reg;
    slot_rec_t         item_reg;
    logic [TIME_W-1:0] now_reg;

    // Removed entry and its expiry.
    slot_rec_t         rec_reg;
    logic [TIME_W-1:0] elapsed_reg;
    logic              exp_reg;

    // Slot memory.
    slot_rec_t         mem [SLOTS];
    slot_rec_t         rdata_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              mem_we;

    scan_ctl_t         scan_ctl;
    scan_res_t         scan_res;

    logic              accept;
    logic              out_free;
    logic              issue;
    logic              scan_last;
    logic              src_ok;
    logic [SIDX_W-1:0] sidx;
    logic [VAL_W-1:0]  add_val;
    logic [VAL_W-1:0]  ssum_new;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign issue     = (state_reg == S_SCAN) && (scan_cnt_reg < (IDX_W + 1)'(SLOTS));
    assign scan_last = smp_vld_reg && (smp_idx_reg == IDX_W'(SLOTS - 1));
    assign mem_we    = (state_reg == S_WRITE);
    assign rd_addr   = (state_reg == S_FETCH) ? scan_res.best_idx : scan_cnt_reg[IDX_W-1:0];

    assign src_ok   = (int'(rec_reg.source) < SOURCES);
    assign sidx     = SIDX_W'(rec_reg.source);
    assign add_val  = exp_reg ? '0 : rec_reg.value;
    assign ssum_new = src_sum_reg[sidx] + add_val;

    assign scan_ctl.start     = accept;
    assign scan_ctl.sample    = smp_vld_reg;
    assign scan_ctl.is_remove = (act_reg == ACT_REMOVE);
    assign scan_ctl.cand      = (act_reg == ACT_REMOVE) ? active_reg[smp_idx_reg]
                                                        : !active_reg[smp_idx_reg];
    assign scan_ctl.idx       = smp_idx_reg;
    assign scan_ctl.key       = rdata_reg.prio;

    psb_scan_unit u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (scan_ctl),
        .res   (scan_res)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[scan_res.best_idx] <= item_reg;
        end
        rdata_reg <= mem[rd_addr];
    end

    // Item and removed-entry payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg           <= action;
            item_reg.value    <= item_value;
            item_reg.prio     <= item_priority;
            item_reg.source   <= item_source;
            item_reg.created  <= now_seconds;
            item_reg.lifetime <= item_lifetime;
            now_reg           <= now_seconds;
        end
        if (state_reg == S_LOAD)
        begin
            rec_reg     <= rdata_reg;
            elapsed_reg <= now_reg - rdata_reg.created;
        end
        if (state_reg == S_CHECK)
        begin
            exp_reg <= (elapsed_reg > TIME_W'(rec_reg.lifetime));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_cnt_reg  <= '0;
            smp_vld_reg   <= 1'b0;
            smp_idx_reg   <= '0;
            active_reg    <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            for (int s = 0; s < SOURCES; s++)
            begin
                src_sum_reg[s] <= '0;
            end
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_res_reg   <= '0;
            out_total_reg <= '0;
            out_occ_reg   <= '0;
        end
        else
        begin
            smp_vld_reg <= issue;
            smp_idx_reg <= scan_cnt_reg[IDX_W-1:0];
            if (issue)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            // In S_DONE the output register is reloaded instead.
            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        scan_cnt_reg <= '0;
                        if ((action == ACT_INSERT) && (count_reg == CNT_W'(SLOTS)))
                        begin
                            res_reg.status <= STAT_FULL;
                            state_reg      <= S_DONE;
                        end
                        else if ((action == ACT_REMOVE) && (count_reg == '0))
                        begin
                            res_reg.status <= STAT_EMPTY;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            res_reg.status <= STAT_OK;
                            state_reg      <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (scan_last)
                    begin
                        state_reg <= (act_reg == ACT_REMOVE) ? S_FETCH : S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    active_reg[scan_res.best_idx] <= 1'b1;
                    count_reg                     <= count_reg + 1'b1;
                    state_reg                     <= S_DONE;
                end
                S_FETCH:
                begin
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    state_reg <= S_ACCUM;
                end
                S_ACCUM:
                begin
                    active_reg[scan_res.best_idx] <= 1'b0;
                    count_reg                     <= count_reg - 1'b1;
                    total_reg                     <= total_reg + add_val;
                    res_reg.value                 <= rec_reg.value;
                    res_reg.prio                  <= rec_reg.prio;
                    res_reg.source                <= rec_reg.source;
                    res_reg.expired               <= exp_reg;
                    if (src_ok)
                    begin
                        src_sum_reg[sidx] <= ssum_new;
                        res_reg.ssum      <= ssum_new;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // Sums and occupancy are already updated for this word.
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_res_reg   <= res_reg;
                        out_total_reg <= total_reg;
                        out_occ_reg   <= OCC_W'(count_reg);
                        res_reg       <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_res_reg.status;
    assign out_value    = out_res_reg.value;
    assign out_priority = out_res_reg.prio;
    assign out_source   = out_res_reg.source;
    assign expired      = out_res_reg.expired;
    assign total_sum    = out_total_reg;
    assign source_sum   = out_res_reg.ssum;
    assign occupancy    = out_occ_reg;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg && $stable(out_res_reg) &&
                                         $stable(out_total_reg) && $stable(out_occ_reg))
        else $error("stalled result word changed");

    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(active_reg)))
        else $error("occupancy count differs from the active slots");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(SLOTS))
        else $error("occupancy count above the slot count");

endmodule

`default_nettype wire

FILE: rtl/core/psb_scan_unit.sv
// ----------------------------------------------------------------------------
// Slot scan unit
// Shared compare unit that walks the slots one sample per cycle and keeps
// either the first free slot or the active slot with the smallest priority.
// ----------------------------------------------------------------------------
`default_nettype none

module psb_scan_unit (
    input  wire                 clk,
    input  wire                 rst_n,
    input  psb_pkg::scan_ctl_t  ctl,
    output psb_pkg::scan_res_t  res
);
    import psb_pkg::*;

    logic              found_reg;
    logic              found_next;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [IDX_W-1:0]  best_idx_next;
    logic [PRIO_W-1:0] best_key_reg;
    logic [PRIO_W-1:0] best_key_next;
    logic              take;

    // A strictly smaller key wins, so ties keep the lower slot seen first.
    assign take = !ctl.start && ctl.sample && ctl.cand &&
                  (!found_reg || (ctl.is_remove && (ctl.key < best_key_reg)));

    always_comb
    begin
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_key_next = best_key_reg;
        if (ctl.start)
        begin
            found_next = 1'b0;
        end
        else if (take)
        begin
            found_next    = 1'b1;
            best_idx_next = ctl.idx;
            best_key_next = ctl.key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg    <= 1'b0;
            best_idx_reg <= '0;
            best_key_reg <= '0;
        end
        else
        begin
            found_reg    <= found_next;
            best_idx_reg <= best_idx_next;
            best_key_reg <= best_key_next;
        end
    end

    assign res.found    = found_reg;
    assign res.best_idx = best_idx_reg;

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |=> !found_reg)
        else $error("scan start did not clear the found flag");

    a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> found_reg && (best_idx_reg == $past(ctl.idx)))
        else $error("accepted candidate not recorded");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!ctl.start && !take) |=> $stable(best_idx_reg) && $stable(found_reg))
        else $error("scan result changed without a candidate");

endmodule

`default_nettype wire
